// File: sv/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/spnh_pkg.sv
// Shared types and constants for the shortest-path next-hop core
package spnh_pkg;

    localparam int MAX_NODES = 64;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int DIST_W    = IDX_W + 1;

    localparam logic [1:0] OP_EDGE   = 2'd0;
    localparam logic [1:0] OP_QUERY1 = 2'd1;
    localparam logic [1:0] OP_QUERY2 = 2'd2;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(6);
    localparam logic [CNT_W-1:0] NODE_LIMIT     = CNT_W'(MAX_NODES);

    typedef struct packed {
        logic              reached;
        logic              settled;
        logic [DIST_W-1:0] path_len;
        logic [IDX_W-1:0]  pred;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    typedef struct packed {
        node_t entry;
        logic  cand;
    } relax_t;

endpackage

// File: sv/spnh_ram.sv
// Generic single-write, single-read synchronous RAM with registered read
module spnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/spnh_relax.sv
// Edge relaxation and candidate test for one node entry
module spnh_relax import spnh_pkg::*; (
    input  node_t             entry,
    input  logic              edge_bit,
    input  logic [IDX_W-1:0]  cur,
    input  logic [DIST_W-1:0] cur_dist,
    output relax_t            result
);

    logic [DIST_W-1:0] new_dist;
    node_t             upd;

    assign new_dist = cur_dist + DIST_W'(1);

    always_comb
    begin
        upd = entry;
        if (edge_bit && (!entry.reached || (entry.path_len > new_dist)))
        begin
            upd.reached  = 1'b1;
            upd.path_len = new_dist;
            upd.pred     = cur;
        end
        result.entry = upd;
        result.cand  = upd.reached && !upd.settled;
    end

endmodule

// File: sv/shortest_path_next_hop_core.sv
// Top level of the shortest-path next-hop core
// A request is taken when start is high and busy is low. Opcode 0 writes an
// undirected edge into the adjacency RAM and gives no result. Opcodes 1 and 2
// run a unit-weight Dijkstra search from source_node over the first node_count
// nodes (capped at 64) and answer with one done strobe carrying next_hop and
// found; opcode 3 is dropped. The receiver cannot stall: done is high for
// exactly one cycle. A query first initialises the node-state RAM, then makes
// one pass over the node-state RAM per settled node, one entry per cycle, then
// selects the target and walks the predecessor chain back to the source. busy
// stays high throughout, so a new request is taken only once the last is done.
// The node-state RAM has a single read port. node_count is written through
// cfg_we/cfg_wdata; the user must write it only while busy is low, as the
// block itself does not enforce this.
module shortest_path_next_hop_core import spnh_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       opcode,
    input  logic [5:0]       edge_end_a,
    input  logic [5:0]       edge_end_b,
    input  logic             edge_present,
    input  logic [5:0]       source_node,
    input  logic [5:0]       first_target,
    input  logic [5:0]       second_target,
    input  logic             cfg_we,
    input  logic [6:0]       cfg_wdata,
    output logic             done,
    output logic [5:0]       next_hop,
    output logic             found
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EA    = 4'd1;
    localparam logic [3:0] ST_EB_RD = 4'd2;
    localparam logic [3:0] ST_EB    = 4'd3;
    localparam logic [3:0] ST_INIT  = 4'd4;
    localparam logic [3:0] ST_ROW   = 4'd5;
    localparam logic [3:0] ST_SCAN  = 4'd6;
    localparam logic [3:0] ST_PICK  = 4'd7;
    localparam logic [3:0] ST_T1    = 4'd8;
    localparam logic [3:0] ST_T2    = 4'd9;
    localparam logic [3:0] ST_TSEL  = 4'd10;
    localparam logic [3:0] ST_WRD   = 4'd11;
    localparam logic [3:0] ST_WCHK  = 4'd12;

    // control registers
    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    node_count_reg;
    logic [MAX_NODES-1:0] row_valid_reg, row_valid_next;
    logic                adj_vld_reg;
    logic                done_reg, done_next;
    logic                proc_valid_reg, proc_valid_next;
    logic                any_reg, any_next;

    // datapath registers
    logic [IDX_W-1:0]  a_reg, a_next;
    logic [IDX_W-1:0]  b_reg, b_next;
    logic              p_reg, p_next;
    logic [IDX_W-1:0]  src_reg, src_next;
    logic [IDX_W-1:0]  t1_reg, t1_next;
    logic [IDX_W-1:0]  t2_reg, t2_next;
    logic              two_reg, two_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  proc_idx_reg, proc_idx_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [DIST_W-1:0] cur_dist_reg, cur_dist_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    node_t             best_reg, best_next;
    logic              ok1_reg, ok1_next;
    logic [DIST_W-1:0] d1_reg, d1_next;
    logic [IDX_W-1:0]  reach_reg, reach_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic [5:0]        next_hop_reg, next_hop_next;
    logic              found_reg, found_next;

    // memory ports
    logic                 adj_we;
    logic [IDX_W-1:0]     adj_waddr, adj_raddr;
    logic [MAX_NODES-1:0] adj_wdata, adj_rdata, adj_row;
    logic                 st_we;
    logic [IDX_W-1:0]     st_waddr, st_raddr;
    node_t                st_wdata, st_rdata;

    logic [CNT_W-1:0] n_eff;
    logic             accept;
    relax_t           relax;
    logic             ok2;

    assign accept = start && !busy;
    assign n_eff  = (node_count_reg > NODE_LIMIT) ? NODE_LIMIT : node_count_reg;
    assign adj_row = adj_vld_reg ? adj_rdata : '0;

    spnh_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    spnh_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_node_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    spnh_relax u_relax (
        .entry    (st_rdata),
        .edge_bit (adj_row[proc_idx_reg]),
        .cur      (cur_reg),
        .cur_dist (cur_dist_reg),
        .result   (relax)
    );

    // read address selection
    always_comb
    begin
        case (state_reg)
            ST_IDLE:            adj_raddr = edge_end_a;
            ST_EA, ST_EB_RD:    adj_raddr = b_reg;
            default:            adj_raddr = cur_reg;
        endcase
        case (state_reg)
            ST_SCAN: st_raddr = idx_reg[IDX_W-1:0];
            ST_T1:   st_raddr = t1_reg;
            ST_T2:   st_raddr = t2_reg;
            default: st_raddr = reach_reg;
        endcase
    end

    // t2 entry is on the read port in ST_TSEL
    assign ok2 = two_reg && ({1'b0, t2_reg} < n_eff) && st_rdata.reached &&
                 (t2_reg != src_reg);

    always_comb
    begin
        state_next      = state_reg;
        row_valid_next  = row_valid_reg;
        done_next       = 1'b0;
        proc_valid_next = 1'b0;
        any_next        = any_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        p_next          = p_reg;
        src_next        = src_reg;
        t1_next         = t1_reg;
        t2_next         = t2_reg;
        two_next        = two_reg;
        idx_next        = idx_reg;
        proc_idx_next   = proc_idx_reg;
        cur_next        = cur_reg;
        cur_dist_next   = cur_dist_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        ok1_next        = ok1_reg;
        d1_next         = d1_reg;
        reach_next      = reach_reg;
        steps_next      = steps_reg;
        next_hop_next   = next_hop_reg;
        found_next      = found_reg;
        adj_we          = 1'b0;
        adj_waddr       = a_reg;
        adj_wdata       = adj_row;
        st_we           = 1'b0;
        st_waddr        = proc_idx_reg;
        st_wdata        = relax.entry;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    a_next   = edge_end_a;
                    b_next   = edge_end_b;
                    p_next   = edge_present;
                    src_next = source_node;
                    t1_next  = first_target;
                    t2_next  = second_target;
                    two_next = (opcode == OP_QUERY2);
                    idx_next = '0;
                    if (opcode == OP_EDGE)
                    begin
                        state_next = ST_EA;
                    end
                    else if ((opcode == OP_QUERY1) || (opcode == OP_QUERY2))
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_EA:
            begin
                // row a on the read port: set or clear bit b
                adj_we             = 1'b1;
                adj_waddr          = a_reg;
                adj_wdata          = adj_row;
                adj_wdata[b_reg]   = p_reg;
                row_valid_next[a_reg] = 1'b1;
                state_next         = ST_EB_RD;
            end
            ST_EB_RD:
            begin
                state_next = ST_EB;
            end
            ST_EB:
            begin
                adj_we             = 1'b1;
                adj_waddr          = b_reg;
                adj_wdata          = adj_row;
                adj_wdata[a_reg]   = p_reg;
                row_valid_next[b_reg] = 1'b1;
                state_next         = ST_IDLE;
            end
            ST_INIT:
            begin
                if ({1'b0, src_reg} >= n_eff)
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b0;
                    next_hop_next = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    st_we    = 1'b1;
                    st_waddr = idx_reg[IDX_W-1:0];
                    st_wdata = '0;
                    if (idx_reg[IDX_W-1:0] == src_reg)
                    begin
                        st_wdata.reached = 1'b1;
                        st_wdata.settled = 1'b1;
                    end
                    idx_next = idx_reg + CNT_W'(1);
                    if (idx_reg == n_eff - CNT_W'(1))
                    begin
                        cur_next      = src_reg;
                        cur_dist_next = '0;
                        state_next    = ST_ROW;
                    end
                end
            end
            ST_ROW:
            begin
                idx_next   = '0;
                any_next   = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg < n_eff)
                begin
                    proc_valid_next = 1'b1;
                    proc_idx_next   = idx_reg[IDX_W-1:0];
                    idx_next        = idx_reg + CNT_W'(1);
                end
                if (proc_valid_reg)
                begin
                    st_we    = 1'b1;
                    st_waddr = proc_idx_reg;
                    st_wdata = relax.entry;
                    // strict compare in ascending order keeps the lowest index
                    if (relax.cand &&
                        (!any_reg || (relax.entry.path_len < best_reg.path_len)))
                    begin
                        any_next      = 1'b1;
                        best_idx_next = proc_idx_reg;
                        best_next     = relax.entry;
                    end
                    if ({1'b0, proc_idx_reg} == n_eff - CNT_W'(1))
                    begin
                        proc_valid_next = 1'b0;
                        state_next      = ST_PICK;
                    end
                end
            end
            ST_PICK:
            begin
                if (any_reg)
                begin
                    st_we            = 1'b1;
                    st_waddr         = best_idx_reg;
                    st_wdata         = best_reg;
                    st_wdata.settled = 1'b1;
                    cur_next         = best_idx_reg;
                    cur_dist_next    = best_reg.path_len;
                    state_next       = ST_ROW;
                end
                else
                begin
                    state_next = ST_T1;
                end
            end
            ST_T1:
            begin
                state_next = ST_T2;
            end
            ST_T2:
            begin
                ok1_next   = ({1'b0, t1_reg} < n_eff) && st_rdata.reached &&
                             (t1_reg != src_reg);
                d1_next    = st_rdata.path_len;
                state_next = ST_TSEL;
            end
            ST_TSEL:
            begin
                steps_next = '0;
                if (ok1_reg && ok2)
                begin
                    reach_next = (st_rdata.path_len < d1_reg) ? t2_reg : t1_reg;
                    state_next = ST_WRD;
                end
                else if (ok1_reg || ok2)
                begin
                    reach_next = ok1_reg ? t1_reg : t2_reg;
                    state_next = ST_WRD;
                end
                else
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b0;
                    next_hop_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_WRD:
            begin
                state_next = ST_WCHK;
            end
            ST_WCHK:
            begin
                if (!st_rdata.reached || (reach_reg == src_reg))
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b0;
                    next_hop_next = '0;
                    state_next    = ST_IDLE;
                end
                else if (st_rdata.pred == src_reg)
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b1;
                    next_hop_next = reach_reg;
                    state_next    = ST_IDLE;
                end
                else if (({1'b0, st_rdata.pred} >= n_eff) ||
                         (steps_reg == NODE_LIMIT - CNT_W'(1)))
                begin
                    done_next     = 1'b1;
                    found_next    = 1'b0;
                    next_hop_next = '0;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    reach_next = st_rdata.pred;
                    steps_next = steps_reg + CNT_W'(1);
                    state_next = ST_WRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            row_valid_reg  <= '0;
            adj_vld_reg    <= 1'b0;
            done_reg       <= 1'b0;
            proc_valid_reg <= 1'b0;
            any_reg        <= 1'b0;
            found_reg      <= 1'b0;
            next_hop_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            row_valid_reg  <= row_valid_next;
            adj_vld_reg    <= row_valid_reg[adj_raddr];
            done_reg       <= done_next;
            proc_valid_reg <= proc_valid_next;
            any_reg        <= any_next;
            found_reg      <= found_next;
            next_hop_reg   <= next_hop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        p_reg        <= p_next;
        src_reg      <= src_next;
        t1_reg       <= t1_next;
        t2_reg       <= t2_next;
        two_reg      <= two_next;
        idx_reg      <= idx_next;
        proc_idx_reg <= proc_idx_next;
        cur_reg      <= cur_next;
        cur_dist_reg <= cur_dist_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        ok1_reg      <= ok1_next;
        d1_reg       <= d1_next;
        reach_reg    <= reach_next;
        steps_reg    <= steps_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign next_hop = next_hop_reg;
    assign found    = found_reg;

endmodule

// File: sv/spnh_chk.sv
// Port-level checker for the shortest-path next-hop core
`include "assert_macros.svh"

module spnh_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [5:0] next_hop,
    input logic       found
);

    `CHK_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
    `CHK_ASSERT(a_done_idle, done |-> !busy, "result shown while still busy")
    `CHK_ASSERT(a_miss_zero, (done && !found) |-> (next_hop == 6'd0), "next_hop not zero on miss")
    `CHK_ASSERT(a_busy_cause, $rose(busy) |-> $past(start), "busy rose without a request")
    `CHK_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> (!done && !busy), "activity during reset")

endmodule

bind shortest_path_next_hop_core spnh_chk u_spnh_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .next_hop (next_hop),
    .found    (found)
);

// File: sim/testbench.sv
// Testbench for the shortest-path next-hop core: self-checking, directed and random requests
`timescale 1ns / 100ps

module testbench import spnh_pkg::*;;

    localparam int CYCLE_LIMIT = 3000000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] opcode;
    logic [5:0] edge_end_a;
    logic [5:0] edge_end_b;
    logic       edge_present;
    logic [5:0] source_node;
    logic [5:0] first_target;
    logic [5:0] second_target;
    logic       cfg_we;
    logic [6:0] cfg_wdata;
    logic       done;
    logic [5:0] next_hop;
    logic       found;

    localparam logic [1:0] OP_DROP = 2'd3;

    shortest_path_next_hop_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .edge_end_a(edge_end_a), .edge_end_b(edge_end_b),
        .edge_present(edge_present), .source_node(source_node),
        .first_target(first_target), .second_target(second_target),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .done(done), .next_hop(next_hop), .found(found)
    );

    // Own copy of the graph and of node_count
    bit [63:0]  adj_rows [64];
    logic [6:0] nodes_cfg;

    // Expected answers, {found, next_hop}, oldest first
    logic [6:0] hop_queue [$];
    int         mismatches;
    int         cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Unit-weight Dijkstra, lowest index wins a tie, then a walk back to the source
    function automatic logic [6:0] predict_hop(logic [1:0] op, logic [5:0] src,
                                                logic [5:0] t1, logic [5:0] t2);
        int  n;
        int  path_len [64];
        int  pred [64];
        bit  reached [64];
        bit  settled [64];
        bit  has_pred [64];
        int  cur;
        int  best;
        int  reach;
        bit  any;
        bit  ok1;
        bit  ok2;
        n = (nodes_cfg > 64) ? 64 : int'(nodes_cfg);
        if (int'(src) >= n)
            return 7'd0;
        for (int i = 0; i < 64; i++)
        begin
            path_len[i] = 0; pred[i] = 0; reached[i] = 0; settled[i] = 0; has_pred[i] = 0;
        end
        reached[src] = 1;
        settled[src] = 1;
        cur = src;
        for (int c = 0; c < n; c++)
        begin
            any = 0;
            best = 0;
            for (int j = 0; j < n; j++)
                if (adj_rows[cur][j] && (!reached[j] || path_len[j] > path_len[cur] + 1))
                begin
                    reached[j] = 1;
                    path_len[j] = path_len[cur] + 1;
                    pred[j] = cur;
                    has_pred[j] = 1;
                end
            for (int i = 0; i < n; i++)
                if (reached[i] && !settled[i] && (!any || path_len[i] < path_len[best]))
                begin
                    any = 1;
                    best = i;
                end
            if (!any)
                break;
            settled[best] = 1;
            cur = best;
        end
        ok1 = (int'(t1) < n) && has_pred[t1];
        ok2 = (op == OP_QUERY2) && (int'(t2) < n) && has_pred[t2];
        if (!ok1 && !ok2)
            return 7'd0;
        if (ok1 && ok2)
            reach = (path_len[t2] < path_len[t1]) ? t2 : t1;
        else
            reach = ok1 ? t1 : t2;
        for (int s = 0; s < 64; s++)
        begin
            if (!has_pred[reach])
                return 7'd0;
            if (pred[reach] == src)
                return {1'b1, 6'(reach)};
            reach = pred[reach];
            if (reach >= n)
                return 7'd0;
        end
        return 7'd0;
    endfunction

    // Result checker: every done strobe against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (hop_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: found=%0d next_hop=%0d", found, next_hop);
            end
            else
            begin
                logic [6:0] want;
                want = hop_queue.pop_front();
                if (found !== want[6] || next_hop !== want[5:0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected found=%0d hop=%0d, got found=%0d hop=%0d",
                                 want[6], want[5:0], found, next_hop);
                end
            end
        end
    end

    // Present one request and hold it until taken; start stays high afterwards
    task automatic send_req(logic [1:0] op, logic [5:0] a, logic [5:0] b, logic p,
                            logic [5:0] src, logic [5:0] t1, logic [5:0] t2);
        opcode        <= op;
        edge_end_a    <= a;
        edge_end_b    <= b;
        edge_present  <= p;
        source_node   <= src;
        first_target  <= t1;
        second_target <= t2;
        start         <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == OP_EDGE)
        begin
            adj_rows[a][b] = p;
            adj_rows[b][a] = p;
        end
        else if (op != OP_DROP)
            hop_queue = {hop_queue, predict_hop(op, src, t1, t2)};
    endtask

    task automatic pause(int lo, int hi);
        start <= 1'b0;
        repeat ($urandom_range(hi, lo)) @(posedge clk);
    endtask

    task automatic edge_req(int a, int b, bit p);
        send_req(OP_EDGE, 6'(a), 6'(b), p, 6'($urandom), 6'($urandom), 6'($urandom));
    endtask

    task automatic query_req(logic [1:0] op, int src, int t1, int t2);
        send_req(op, 6'($urandom), 6'($urandom), 1'($urandom), 6'(src), 6'(t1), 6'(t2));
    endtask

    // node_count only changes once the core has drained
    task automatic set_node_count(logic [6:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (hop_queue.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        nodes_cfg = value;
    endtask

    // Small hand-built graph at the reset node count
    task automatic test_directed_paths();
        edge_req(0, 1, 1);
        edge_req(1, 2, 1);
        edge_req(2, 3, 1);
        edge_req(0, 4, 1);
        edge_req(4, 3, 1);
        edge_req(5, 5, 1);              // self loop
        edge_req(6, 7, 1);              // beyond node_count
        edge_req(63, 63, 1);
        query_req(OP_QUERY1, 0, 3, 0);
        query_req(OP_QUERY1, 3, 0, 0);
        query_req(OP_QUERY1, 0, 0, 0);  // target is the source
        query_req(OP_QUERY1, 0, 5, 0);  // unreachable
        query_req(OP_QUERY1, 0, 7, 0);  // target beyond node_count
        query_req(OP_QUERY1, 6, 7, 0);  // source beyond node_count
        query_req(OP_QUERY2, 0, 3, 2);  // equal distance, first wins
        query_req(OP_QUERY2, 0, 3, 4);  // second nearer
        query_req(OP_QUERY2, 0, 5, 2);  // only second reachable
        query_req(OP_QUERY2, 63, 63, 63);
        send_req(OP_DROP, 6'd0, 6'd1, 1'b0, 6'd0, 6'd1, 6'd2);
        query_req(OP_QUERY1, 0, 1, 0);  // dropped request left edge 0-1 alone
        edge_req(0, 4, 0);
        query_req(OP_QUERY1, 0, 3, 0);
        pause(1, 3);
    endtask

    // Extremes of node_count
    task automatic test_node_count_extremes();
        set_node_count(7'd0);
        query_req(OP_QUERY2, 0, 1, 2);
        set_node_count(7'd1);
        query_req(OP_QUERY1, 0, 0, 0);
        set_node_count(7'd2);
        query_req(OP_QUERY1, 0, 1, 0);
        query_req(OP_QUERY1, 1, 0, 0);
        set_node_count(7'd127);         // capped at 64
        edge_req(0, 63, 1);
        edge_req(62, 63, 1);
        query_req(OP_QUERY2, 0, 62, 63);
        query_req(OP_QUERY1, 63, 1, 0);
        set_node_count(7'd64);
        query_req(OP_QUERY1, 62, 0, 0);
        pause(1, 2);
    endtask

    // Random graphs with bursts and gaps; mostly small node counts
    task automatic test_random_graphs();
        int n;
        int left;
        int burst;
        int roll;
        for (int phase = 0; phase < 6; phase++)
        begin
            n = (phase == 5) ? 64 : $urandom_range(16, 4);
            set_node_count(7'(n));
            left = (phase == 5) ? 6 : 22;
            while (left > 0)
            begin
                burst = ($urandom_range(3, 0) == 0) ? 12 : $urandom_range(6, 1);
                for (int k = 0; k < burst && left > 0; k++)
                begin
                    roll = $urandom_range(99, 0);
                    if (roll < 50)
                        edge_req($urandom_range(n - 1, 0), $urandom_range(n - 1, 0),
                                 $urandom_range(3, 0) != 0);
                    else if (roll < 58)
                        edge_req($urandom_range(63, 0), $urandom_range(63, 0),
                                 1'($urandom));
                    else if (roll < 90)
                        query_req(1'($urandom) ? OP_QUERY2 : OP_QUERY1,
                                  $urandom_range(n - 1, 0), $urandom_range(n - 1, 0),
                                  $urandom_range(n - 1, 0));
                    else if (roll < 96)
                        query_req(2'($urandom_range(2, 1)), $urandom_range(63, 0),
                                  $urandom_range(63, 0), $urandom_range(63, 0));
                    else
                        send_req(OP_DROP, 6'($urandom), 6'($urandom), 1'($urandom),
                                 6'($urandom), 6'($urandom), 6'($urandom));
                    left--;
                end
                pause(1, 8);
            end
        end
    endtask

    initial
    begin
        int drain;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        opcode        <= OP_EDGE;
        edge_end_a    <= '0;
        edge_end_b    <= '0;
        edge_present  <= 1'b0;
        source_node   <= '0;
        first_target  <= '0;
        second_target <= '0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        mismatches    = 0;
        nodes_cfg     = 7'd6;
        foreach (adj_rows[i])
            adj_rows[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_paths();
        test_node_count_extremes();
        test_random_graphs();

        start <= 1'b0;
        drain = 0;
        while ((hop_queue.size() != 0 || busy) && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (50) @(posedge clk);
        if (mismatches == 0 && hop_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
